/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL modules.
// Both expect signals named clk and rst in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// The expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  `ASSERT_PROP(label, !(expr), msg)

`endif

/* hdl/lcb_pkg.sv */
package lcb_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int TAG_W    = 32;
  localparam int FRAME_W  = 16;
  localparam int KEY_W    = TAG_W + FRAME_W;
  localparam int SIZE_W   = 32;
  localparam int TOTAL_W  = 37;
  localparam int ENTRY_W  = 6;
  localparam int MEM_W    = 32;

  localparam int IN_DATA_W  = TAG_W + FRAME_W + SIZE_W;
  localparam int OUT_USED_W = 1 + TAG_W + FRAME_W + SIZE_W + TOTAL_W + ENTRY_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_MEMORY  = 2'd1;

  localparam logic [ENTRY_W-1:0] RST_MAX_ENTRIES = 6'd32;
  localparam logic [MEM_W-1:0]   RST_MAX_MEMORY  = 32'd268435456;

  typedef struct packed {
    logic load;
    logic lookup;
    logic emit_hit;
    logic check;
    logic evict;
    logic insert;
  } lcb_cmd_t;

  typedef struct packed {
    logic hit;
    logic need_evict;
    logic out_free;
  } lcb_sts_t;

endpackage

/* hdl/lru_cache_count_and_byte_budget_core.sv */
// LRU bookkeeping for a cache bounded by an entry count and a byte budget.
// Input stream s_*: one transaction per access, carrying the key (instance
// tag and frame number) and the byte size the entry would occupy.
// Output stream m_*: on a hit, one final report. On a miss, one report per
// evicted entry (oldest first, tuser low), then a final report (tuser high)
// with tlast set. Each report carries the totals after it.
// Configuration channel cfg_*: index 0 writes the entry limit, index 1 the
// byte budget (zero means no byte limit); it is always ready and is meant
// to be written while the block is idle.
// Sequencing: a hit report is loaded into the output register after the
// lookup and decide states; a miss passes through the check state, then
// the evict and check states once per eviction, before the insert state
// loads the final report. Each report waits for the single output register.
// Flow: one access is handled at a time; s_tready rises in the cycle
// after the final report is loaded.
// A stalled receiver holds the current report in the output register and
// the controller waits before issuing the next one; nothing is dropped.
// Reset (synchronous, active high) empties the table, clears the totals
// and restores the limits to 32 entries and 256 MiB.
module lru_cache_count_and_byte_budget_core
  import lcb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,   // instance_tag, frame_number, entry_size
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,   // hit, out_tag, out_frame, out_size, bytes_in_use, entries_in_use
  output logic                  m_tuser,   // kind
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  lcb_cmd_t cmd;
  lcb_sts_t sts;

  assign cfg_ready = 1'b1;

  lcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lcb_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

/* hdl/lcb_ctrl.sv */
`include "assert_macros.svh"

module lcb_ctrl
  import lcb_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     s_tvalid,
  output logic     s_tready,
  input  lcb_sts_t sts,
  output lcb_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_LOOKUP = 6'b000010,
    S_DECIDE = 6'b000100,
    S_CHECK  = 6'b001000,
    S_EVICT  = 6'b010000,
    S_INSERT = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (!sts.hit) begin
          state_next = S_CHECK;
        end else if (sts.out_free) begin
          cmd.emit_hit = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_CHECK: begin
        cmd.check  = 1'b1;
        state_next = sts.need_evict ? S_EVICT : S_INSERT;
      end
      S_EVICT: begin
        if (sts.out_free) begin
          cmd.evict  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_INSERT: begin
        if (sts.out_free) begin
          cmd.insert = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `ASSERT_PROP(a_emit_needs_room, (cmd.emit_hit || cmd.evict || cmd.insert) |-> sts.out_free, "result issued while output register is occupied")
  `ASSERT_PROP(a_load_then_lookup, cmd.load |=> cmd.lookup, "lookup did not follow an accepted transaction")

endmodule

/* hdl/lcb_dpath.sv */
`include "assert_macros.svh"

module lcb_dpath
  import lcb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
)
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  lcb_cmd_t              cmd,
  output lcb_sts_t              sts,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  output logic                  m_tuser,
  output logic                  m_tlast
);

  localparam int CW    = $clog2(CAPACITY + 1);
  localparam int CW1   = CW + 1;
  localparam int RW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int SUM_W = TOTAL_W + 1;

  logic [ENTRY_W-1:0] max_entries;
  logic [MEM_W-1:0]   max_memory;
  logic [ENTRY_W-1:0] lim;

  logic [KEY_W-1:0]   in_key;
  logic [SIZE_W-1:0]  in_size;

  logic [CAPACITY-1:0] valid;
  logic [KEY_W-1:0]    key   [CAPACITY];
  logic [SIZE_W-1:0]   size  [CAPACITY];
  logic [RW-1:0]       rank  [CAPACITY];

  logic [TOTAL_W-1:0] total;
  logic [CW-1:0]      count;

  logic [CAPACITY-1:0] match_c;
  logic [SIZE_W-1:0]   hit_size_c;
  logic [RW-1:0]       hit_rank_c;
  logic                hit;
  logic [CAPACITY-1:0] hit_vec;
  logic [SIZE_W-1:0]   hit_size;
  logic [RW-1:0]       hit_rank;

  logic [CAPACITY-1:0] vic_c;
  logic [KEY_W-1:0]    vic_key_c;
  logic [SIZE_W-1:0]   vic_size_c;
  logic [CAPACITY-1:0] vic_vec;
  logic [KEY_W-1:0]    vic_key;
  logic [SIZE_W-1:0]   vic_size;

  logic                over_budget;
  logic                need_evict;
  logic [CAPACITY-1:0] free_n;
  logic [CAPACITY-1:0] free_vec;

  logic [CW-1:0]      count_dec;
  logic [CW-1:0]      count_inc;
  logic [TOTAL_W-1:0] total_dec;
  logic [TOTAL_W-1:0] total_inc;

  logic               out_kind;
  logic               out_hit;
  logic [TAG_W-1:0]   out_tag;
  logic [FRAME_W-1:0] out_frame;
  logic [SIZE_W-1:0]  out_size;
  logic [TOTAL_W-1:0] out_bytes;
  logic [ENTRY_W-1:0] out_entries;
  logic               out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_entries <= RST_MAX_ENTRIES;
      max_memory  <= RST_MAX_MEMORY;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MAX_ENTRIES: max_entries <= cfg_data[ENTRY_W-1:0];
        REG_MAX_MEMORY:  max_memory  <= cfg_data[MEM_W-1:0];
        default: ;
      endcase
    end
  end

  // A count limit of zero acts as one, and one above the table size acts as the table size.
  always_comb begin
    if (max_entries == '0) begin
      lim = ENTRY_W'(1);
    end else if (max_entries > ENTRY_W'(CAPACITY)) begin
      lim = ENTRY_W'(CAPACITY);
    end else begin
      lim = max_entries;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_key  <= {s_tdata[TAG_W-1:0], s_tdata[TAG_W+FRAME_W-1:TAG_W]};
      in_size <= s_tdata[IN_DATA_W-1:TAG_W+FRAME_W];
    end
  end

  always_comb begin
    hit_size_c = '0;
    hit_rank_c = '0;
    vic_key_c  = '0;
    vic_size_c = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      match_c[i] = valid[i] && (key[i] == in_key);
      vic_c[i]   = valid[i] && ((CW1'(rank[i]) + CW1'(1)) == CW1'(count));
      hit_size_c = hit_size_c | ({SIZE_W{match_c[i]}} & size[i]);
      hit_rank_c = hit_rank_c | ({RW{match_c[i]}} & rank[i]);
      vic_key_c  = vic_key_c  | ({KEY_W{vic_c[i]}} & key[i]);
      vic_size_c = vic_size_c | ({SIZE_W{vic_c[i]}} & size[i]);
    end
  end

  assign over_budget = (SUM_W'(total) + SUM_W'(in_size)) > SUM_W'(max_memory);
  assign need_evict  = ((ENTRY_W'(count) >= lim) ||
                        ((count != '0) && (max_memory != '0) && over_budget)) && (|vic_c);

  assign free_n   = ~valid;
  assign free_vec = free_n & (~free_n + CAPACITY'(1));

  assign count_dec = count - CW'(1);
  assign count_inc = count + CW'(1);
  assign total_dec = total - TOTAL_W'(vic_size);
  assign total_inc = total + TOTAL_W'(in_size);

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      hit      <= |match_c;
      hit_vec  <= match_c;
      hit_size <= hit_size_c;
      hit_rank <= hit_rank_c;
    end
    if (cmd.check) begin
      vic_vec  <= vic_c;
      vic_key  <= vic_key_c;
      vic_size <= vic_size_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      total <= '0;
    end else if (cmd.evict) begin
      valid <= valid & ~vic_vec;
      count <= count_dec;
      total <= total_dec;
    end else if (cmd.insert) begin
      valid <= valid | free_vec;
      count <= count_inc;
      total <= total_inc;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < CAPACITY; j++) begin
      if (cmd.emit_hit) begin
        if (hit_vec[j]) begin
          rank[j] <= '0;
        end else if (valid[j] && (rank[j] < hit_rank)) begin
          rank[j] <= rank[j] + RW'(1);
        end
      end else if (cmd.insert) begin
        if (free_vec[j]) begin
          key[j]  <= in_key;
          size[j] <= in_size;
          rank[j] <= '0;
        end else if (valid[j]) begin
          rank[j] <= rank[j] + RW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_hit || cmd.evict || cmd.insert) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_hit) begin
      out_kind    <= 1'b1;
      out_hit     <= 1'b1;
      out_tag     <= in_key[KEY_W-1:FRAME_W];
      out_frame   <= in_key[FRAME_W-1:0];
      out_size    <= hit_size;
      out_bytes   <= total;
      out_entries <= ENTRY_W'(count);
      out_last    <= 1'b1;
    end else if (cmd.evict) begin
      out_kind    <= 1'b0;
      out_hit     <= 1'b0;
      out_tag     <= vic_key[KEY_W-1:FRAME_W];
      out_frame   <= vic_key[FRAME_W-1:0];
      out_size    <= vic_size;
      out_bytes   <= total_dec;
      out_entries <= ENTRY_W'(count_dec);
      out_last    <= 1'b0;
    end else if (cmd.insert) begin
      out_kind    <= 1'b1;
      out_hit     <= 1'b0;
      out_tag     <= in_key[KEY_W-1:FRAME_W];
      out_frame   <= in_key[FRAME_W-1:0];
      out_size    <= in_size;
      out_bytes   <= total_inc;
      out_entries <= ENTRY_W'(count_inc);
      out_last    <= 1'b1;
    end
  end

  assign m_tdata = {{OUT_PAD_W{1'b0}}, out_entries, out_bytes, out_size, out_frame,
                    out_tag, out_hit};
  assign m_tuser = out_kind;
  assign m_tlast = out_last;

  assign sts.hit        = hit;
  assign sts.need_evict = need_evict;
  assign sts.out_free   = !m_tvalid || m_tready;

  `ASSERT_PROP(a_count_matches_valid, $countones(valid) == int'(count), "entry count differs from number of valid entries")
  `ASSERT_NEVER(a_count_bound, count > CW'(CAPACITY), "entry count above table size")
  `ASSERT_PROP(a_single_match, $onehot0(match_c), "key present in more than one entry")
  `ASSERT_PROP(a_single_victim, (cmd.check && need_evict) |-> $onehot(vic_c), "eviction without a unique oldest entry")

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import lcb_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int IDLE_PCT    = 14;
  localparam int QUIET_LIMIT = 2000;
  localparam int TAG_POOL    = 6;

  localparam int OFF_TAG     = 1;
  localparam int OFF_FRAME   = OFF_TAG + TAG_W;
  localparam int OFF_SIZE    = OFF_FRAME + FRAME_W;
  localparam int OFF_BYTES   = OFF_SIZE + SIZE_W;
  localparam int OFF_ENTRIES = OFF_BYTES + TOTAL_W;

  typedef struct {
    bit                  kind;
    bit                  hit;
    logic [TAG_W-1:0]    tag;
    logic [FRAME_W-1:0]  frame;
    logic [SIZE_W-1:0]   size;
    logic [TOTAL_W-1:0]  bytes;
    logic [ENTRY_W-1:0]  entries;
    bit                  last;
  } report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  m_tuser;
  logic                  m_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  logic [KEY_W-1:0]   slot_key  [CAPACITY_DEF];
  logic [SIZE_W-1:0]  slot_size [CAPACITY_DEF];
  bit                 slot_live [CAPACITY_DEF];
  int unsigned        slot_rank [CAPACITY_DEF];
  logic [TOTAL_W-1:0] bytes_held = '0;
  int unsigned        live_count = 0;
  logic [ENTRY_W-1:0] entry_limit = RST_MAX_ENTRIES;
  logic [MEM_W-1:0]   byte_budget = RST_MAX_MEMORY;

  report_t     pending_reports[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  bit          steady_flow = 1'b0;

  lru_cache_count_and_byte_budget_core u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  function automatic void push_report(bit kind, bit hit, logic [KEY_W-1:0] key,
                                      logic [SIZE_W-1:0] size, bit last);
    report_t r;
    r.kind    = kind;
    r.hit     = hit;
    r.tag     = key[KEY_W-1:FRAME_W];
    r.frame   = key[FRAME_W-1:0];
    r.size    = size;
    r.bytes   = bytes_held;
    r.entries = live_count[ENTRY_W-1:0];
    r.last    = last;
    pending_reports.push_back(r);
  endfunction

  // Looks up the key, evicts the oldest entries while either limit is
  // exceeded, inserts on a miss, and queues every report this causes.
  function automatic void predict_access(logic [TAG_W-1:0] tag, logic [FRAME_W-1:0] frame,
                                         logic [SIZE_W-1:0] size);
    logic [KEY_W-1:0] key;
    int unsigned      lim;
    int               victim;
    int               free_slot;
    key = {tag, frame};
    lim = (entry_limit == '0) ? 1 : int'(entry_limit);
    if (lim > CAPACITY_DEF) lim = CAPACITY_DEF;
    for (int i = 0; i < CAPACITY_DEF; i++) begin
      if (slot_live[i] && slot_key[i] == key) begin
        for (int j = 0; j < CAPACITY_DEF; j++)
          if (slot_live[j] && slot_rank[j] < slot_rank[i]) slot_rank[j]++;
        slot_rank[i] = 0;
        push_report(1'b1, 1'b1, key, slot_size[i], 1'b1);
        return;
      end
    end
    while (live_count >= lim || (live_count > 0 && byte_budget != 0 &&
           64'(bytes_held) + 64'(size) > 64'(byte_budget))) begin
      victim = -1;
      for (int i = 0; i < CAPACITY_DEF; i++)
        if (slot_live[i] && slot_rank[i] + 1 == live_count) victim = i;
      if (victim < 0) break;
      slot_live[victim] = 1'b0;
      live_count--;
      bytes_held = bytes_held - TOTAL_W'(slot_size[victim]);
      push_report(1'b0, 1'b0, slot_key[victim], slot_size[victim], 1'b0);
    end
    free_slot = -1;
    for (int i = 0; i < CAPACITY_DEF; i++)
      if (!slot_live[i] && free_slot < 0) free_slot = i;
    if (free_slot >= 0) begin
      for (int j = 0; j < CAPACITY_DEF; j++)
        if (slot_live[j]) slot_rank[j]++;
      slot_live[free_slot] = 1'b1;
      slot_key[free_slot]  = key;
      slot_size[free_slot] = size;
      slot_rank[free_slot] = 0;
      live_count++;
      bytes_held = bytes_held + TOTAL_W'(size);
    end
    push_report(1'b1, 1'b0, key, size, 1'b1);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  function automatic logic [SIZE_W-1:0] pick_size(logic [MEM_W-1:0] budget);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 2) return $urandom;
    if (budget == 0 || roll < 5) return $urandom_range(0, 4095);
    return $urandom_range(0, budget / 4);
  endfunction

  task automatic send_access(input logic [TAG_W-1:0] tag, input logic [FRAME_W-1:0] frame,
                             input logic [SIZE_W-1:0] size);
    cfg_valid <= 1'b0;
    while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {size, frame, tag};
    do @(posedge clk); while (!s_tready);
    predict_access(tag, frame, size);
  endtask

  task automatic wait_for_reports();
    s_tvalid  <= 1'b0;
    cfg_valid <= 1'b0;
    do @(posedge clk); while (pending_reports.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    if (index == REG_MAX_ENTRIES) entry_limit = value[ENTRY_W-1:0];
    else if (index == REG_MAX_MEMORY) byte_budget = value;
  endtask

  task automatic set_limits(input logic [CFG_DATA_W-1:0] entries,
                            input logic [CFG_DATA_W-1:0] memory);
    wait_for_reports();
    write_reg(REG_MAX_ENTRIES, entries);
    write_reg(REG_MAX_MEMORY, memory);
  endtask

  // Reset limits: extreme keys, hits, and entries at or beyond the budget.
  task automatic test_field_extremes();
    send_access(32'h0000_0000, 16'h0000, 32'h0000_0000);
    send_access(32'hFFFF_FFFF, 16'hFFFF, 32'h1000_0000);
    send_access(32'h0000_0000, 16'h0000, 32'h0000_0005);
    send_access(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_access(32'h1234_5678, 16'h0001, 32'h0000_0001);
    wait_for_reports();
    send_access(32'hA5A5_A5A5, 16'h5A5A, 32'hFFFF_FFFF);
    send_access(32'h5A5A_5A5A, 16'hA5A5, 32'h0000_0000);
  endtask

  task automatic test_count_limit();
    set_limits(32'hFFFF_FFC2, 32'd0);
    send_access(32'h11, 16'd1, 32'd100);
    send_access(32'h22, 16'd2, 32'd200);
    send_access(32'h33, 16'd3, 32'd300);
    send_access(32'h22, 16'd2, 32'd999);
    send_access(32'h44, 16'd4, 32'd400);
    set_limits(32'd0, 32'd0);
    send_access(32'h55, 16'd5, 32'd50);
    send_access(32'h66, 16'd6, 32'd50);
  endtask

  task automatic test_byte_budget();
    set_limits(32'd32, 32'd1000);
    send_access(32'h100, 16'd1, 32'd400);
    send_access(32'h200, 16'd2, 32'd400);
    send_access(32'h300, 16'd3, 32'd200);
    send_access(32'h400, 16'd4, 32'd0);
    send_access(32'h600, 16'd6, 32'd1000);
    wait_for_reports();
    write_reg(REG_SPARE, 32'hFFFF_FFFF);
    send_access(32'h500, 16'd5, 32'd1);
    set_limits(32'd32, 32'hFFFF_FFFF);
    send_access(32'h700, 16'd7, 32'hFFFF_FFFF);
    send_access(32'h800, 16'd8, 32'd1);
  endtask

  task automatic test_random_traffic(input int n_items, input logic [CFG_DATA_W-1:0] entries,
                                     input logic [CFG_DATA_W-1:0] memory);
    logic [TAG_W-1:0]   tags [TAG_POOL];
    logic [FRAME_W-1:0] frame;
    foreach (tags[i]) tags[i] = $urandom;
    set_limits(entries, memory);
    for (int n = 0; n < n_items; n++) begin
      frame = ($urandom_range(0, 99) < 85) ? FRAME_W'($urandom_range(0, 7))
                                           : FRAME_W'($urandom_range(0, 65535));
      send_access(tags[$urandom_range(0, TAG_POOL - 1)], frame, pick_size(memory));
      if ($urandom_range(0, 19) == 0) wait_for_reports();
    end
  endtask

  always @(posedge clk)
    m_tready <= !rst && (steady_flow || $urandom_range(0, 99) >= IDLE_PCT);

  always @(posedge clk) begin
    report_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result with no expectation waiting: tdata %h", m_tdata);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("kind", 64'(want.kind), 64'(m_tuser));
        check_field("hit", 64'(want.hit), 64'(m_tdata[0]));
        check_field("out_tag", 64'(want.tag), 64'(m_tdata[OFF_TAG +: TAG_W]));
        check_field("out_frame", 64'(want.frame), 64'(m_tdata[OFF_FRAME +: FRAME_W]));
        check_field("out_size", 64'(want.size), 64'(m_tdata[OFF_SIZE +: SIZE_W]));
        check_field("bytes_in_use", 64'(want.bytes), 64'(m_tdata[OFF_BYTES +: TOTAL_W]));
        check_field("entries_in_use", 64'(want.entries),
                    64'(m_tdata[OFF_ENTRIES +: ENTRY_W]));
        check_field("last", 64'(want.last), 64'(m_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_field_extremes();
    test_count_limit();
    test_byte_budget();
    test_random_traffic(20, 32'd8, 32'd20000);
    steady_flow = 1'b1;
    test_random_traffic(35, 32'd63, 32'd0);
    steady_flow = 1'b0;
    test_random_traffic(10, 32'd1, 32'hFFFF_FFFF);
    test_random_traffic(15, 32'd32, $urandom);
    wait_for_reports();
    repeat (20) @(posedge clk);
    if (pending_reports.size() != 0) begin
      $error("%0d expected results never arrived", pending_reports.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
